>>> hw/rtl/pxarp_pkg.sv
`default_nettype none

package pxarp_pkg;

	// Frame layout
	localparam int ETH_HDR   = 14;
	localparam int ARP_LEN   = 28;
	localparam int IP_MIN    = 20;
	localparam int REPLY_LEN = 42;
	localparam int SCAN_LEN  = ETH_HDR + ARP_LEN;
	localparam int IDX_W     = 6;

	localparam logic [15:0] TYPE_IP   = 16'h0800;
	localparam logic [15:0] TYPE_ARP  = 16'h0806;
	localparam logic [15:0] HTYPE_ETH = 16'h0001;
	localparam logic [15:0] OP_REQ    = 16'h0001;
	localparam logic [15:0] OP_REPLY  = 16'h0002;
	localparam logic [7:0]  HLEN_ETH  = 8'd6;
	localparam logic [7:0]  PLEN_IP   = 8'd4;
	localparam logic [3:0]  IP_VER4   = 4'd4;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_GW_MAC = 2'd0;
	localparam logic [1:0] REG_GW_IP  = 2'd1;
	localparam logic [1:0] REG_MASK   = 2'd2;
	localparam logic [1:0] REG_DNS_IP = 2'd3;

	typedef enum logic [2:0] {
		ST_RX,
		ST_SCAN,
		ST_FLUSH,
		ST_DECIDE,
		ST_REPLY
	} state_t;

	function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
		logic [5:0] sh;
		sh = {3'(3'd5 - i), 3'b000};
		return 8'(mac >> sh);
	endfunction

	function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] i);
		logic [4:0] sh;
		sh = {2'(2'd3 - i), 3'b000};
		return 8'(w >> sh);
	endfunction

	// Byte idx of the ARP reply frame, destination MAC first
	function automatic logic [7:0] reply_byte(
		input logic [IDX_W-1:0] idx,
		input logic [47:0]      sha,
		input logic [47:0]      gmac,
		input logic [31:0]      tip,
		input logic [31:0]      sip
	);
		logic [7:0] b;
		b = 8'h00;
		case (idx) inside
			[6'd0:6'd5]:   b = mac_byte(sha, 3'(idx));
			[6'd6:6'd11]:  b = mac_byte(gmac, 3'(idx - 6'd6));
			6'd12:         b = TYPE_ARP[15:8];
			6'd13:         b = TYPE_ARP[7:0];
			6'd14:         b = HTYPE_ETH[15:8];
			6'd15:         b = HTYPE_ETH[7:0];
			6'd16:         b = TYPE_IP[15:8];
			6'd17:         b = TYPE_IP[7:0];
			6'd18:         b = HLEN_ETH;
			6'd19:         b = PLEN_IP;
			6'd20:         b = OP_REPLY[15:8];
			6'd21:         b = OP_REPLY[7:0];
			[6'd22:6'd27]: b = mac_byte(gmac, 3'(idx - 6'd22));
			[6'd28:6'd31]: b = word_byte(tip, 2'(idx - 6'd28));
			[6'd32:6'd37]: b = mac_byte(sha, 3'(idx - 6'd32));
			[6'd38:6'd41]: b = word_byte(sip, 2'(idx - 6'd38));
			default:       b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/proxy_arp_responder_top.sv
`default_nettype none
// Proxy ARP responder: one guest frame byte per cycle while receiving.
// After the final byte, s_tready drops for a scan over the single read port of the
// header memory, a flush state and a decision state. If the frame earns a reply, it
// then streams 42 bytes at one per cycle while the sink is ready, and s_tready stays
// low until the 42nd reply byte is loaded.
// Reset (arst_n low) clears control, configuration and the guest address at once;
// the header memory is not cleared.
module proxy_arp_responder_top #(
	parameter int HEADER_BYTES = 42
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	// Guest frame stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] frame_byte
	input  wire logic        s_tlast,  // frame_end
	input  wire logic        s_tuser,  // [0] target_leased
	// Reply stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,  // [7:0] reply_byte
	output logic             m_tlast   // reply_end
);

	localparam int CW = $clog2(HEADER_BYTES + 1);
	localparam int AW = $clog2(HEADER_BYTES);
	localparam int IW = pxarp_pkg::IDX_W;

	// Configuration registers
	logic [47:0] gw_mac_q;
	logic [31:0] gw_ip_q;
	logic [31:0] mask_q;
	logic [31:0] dns_ip_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_mac_q <= '0;
			gw_ip_q  <= '0;
			mask_q   <= '0;
			dns_ip_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				pxarp_pkg::REG_GW_MAC: gw_mac_q <= pwdata[47:0];
				pxarp_pkg::REG_GW_IP:  gw_ip_q  <= pwdata[31:0];
				pxarp_pkg::REG_MASK:   mask_q   <= pwdata[31:0];
				pxarp_pkg::REG_DNS_IP: dns_ip_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			pxarp_pkg::REG_GW_MAC: prdata = {16'h0000, gw_mac_q};
			pxarp_pkg::REG_GW_IP:  prdata = {32'h0, gw_ip_q};
			pxarp_pkg::REG_MASK:   prdata = {32'h0, mask_q};
			pxarp_pkg::REG_DNS_IP: prdata = {32'h0, dns_ip_q};
			default:               prdata = '0;
		endcase
	end

	// Control state
	pxarp_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;     // bytes of the current frame, saturating
	logic [CW-1:0] len_q;       // length of the frame under classification
	logic          leased_q;
	logic [IW-1:0] rd_idx_q;    // scan address
	logic [IW-1:0] tx_idx_q;    // reply byte index
	logic [31:0]   guest_ip_q;

	logic          in_xact;
	logic          stored;
	logic [CW-1:0] count_next;
	logic          rd_en;
	logic          scan_last;
	logic          tx_load;
	logic          tx_last;
	logic          do_reply;
	logic          learn;
	logic [31:0]   guest_new;

	assign in_xact    = s_tvalid && s_tready;
	assign stored     = count_q < CW'(HEADER_BYTES);
	assign count_next = stored ? CW'(count_q + 1'b1) : count_q;
	assign scan_last  = rd_idx_q == IW'(pxarp_pkg::SCAN_LEN - 1);
	assign tx_last    = tx_idx_q == IW'(pxarp_pkg::REPLY_LEN - 1);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		tx_load  = 1'b0;
		unique case (state_q)
			pxarp_pkg::ST_RX: begin
				s_tready = 1'b1;
				if (in_xact && s_tlast) state_d = pxarp_pkg::ST_SCAN;
			end
			pxarp_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_last) state_d = pxarp_pkg::ST_FLUSH;
			end
			pxarp_pkg::ST_FLUSH: state_d = pxarp_pkg::ST_DECIDE;
			pxarp_pkg::ST_DECIDE: state_d = do_reply ? pxarp_pkg::ST_REPLY : pxarp_pkg::ST_RX;
			pxarp_pkg::ST_REPLY: begin
				tx_load = !m_tvalid || m_tready;
				if (tx_load && tx_last) state_d = pxarp_pkg::ST_RX;
			end
			default: state_d = pxarp_pkg::ST_RX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pxarp_pkg::ST_RX;
			count_q  <= '0;
			len_q    <= '0;
			leased_q <= 1'b0;
			rd_idx_q <= '0;
			tx_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_xact) begin
				// Hold the final length and leased flag for the scan, restart the count
				if (s_tlast) begin
					count_q  <= '0;
					len_q    <= count_next;
					leased_q <= s_tuser;
					rd_idx_q <= '0;
				end else begin
					count_q <= count_next;
				end
			end
			if (rd_en) rd_idx_q <= IW'(rd_idx_q + 1'b1);
			if (state_q == pxarp_pkg::ST_DECIDE) tx_idx_q <= '0;
			else if (tx_load) tx_idx_q <= IW'(tx_idx_q + 1'b1);
		end
	end

	// Header memory: one write port fed by the stream, one registered read port
	// swept by the scan
	logic [7:0]    hdr_mem [HEADER_BYTES];
	logic [7:0]    rd_data_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_vld_s1;

	always_ff @(posedge clk) begin
		if (in_xact && stored) hdr_mem[count_q[AW-1:0]] <= s_tdata;
		if (rd_en) rd_data_s1 <= hdr_mem[AW'(rd_idx_q)];
		rd_idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_s1 <= 1'b0;
		else         rd_vld_s1 <= rd_en;
	end

	// Header fields, shifted in big-endian as the scan returns bytes
	logic [15:0] etype_q;
	logic [3:0]  ipver_q;
	logic [31:0] ipsrc_q;
	logic [15:0] htype_q;
	logic [15:0] ptype_q;
	logic [7:0]  hlen_q;
	logic [7:0]  plen_q;
	logic [15:0] op_q;
	logic [47:0] sha_q;
	logic [31:0] sip_q;
	logic [31:0] tip_q;

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_idx_s1 == IW'(pxarp_pkg::ETH_HDR)) ipver_q <= rd_data_s1[7:4];
			// IPv4 source address sits at bytes 26 to 29
			if (rd_idx_s1 >= IW'(26) && rd_idx_s1 <= IW'(29))
				ipsrc_q <= {ipsrc_q[23:0], rd_data_s1};
			case (rd_idx_s1) inside
				[6'd12:6'd13]: etype_q <= {etype_q[7:0], rd_data_s1};
				[6'd14:6'd15]: htype_q <= {htype_q[7:0], rd_data_s1};
				[6'd16:6'd17]: ptype_q <= {ptype_q[7:0], rd_data_s1};
				6'd18:         hlen_q  <= rd_data_s1;
				6'd19:         plen_q  <= rd_data_s1;
				[6'd20:6'd21]: op_q    <= {op_q[7:0], rd_data_s1};
				[6'd22:6'd27]: sha_q   <= {sha_q[39:0], rd_data_s1};
				[6'd28:6'd31]: sip_q   <= {sip_q[23:0], rd_data_s1};
				[6'd38:6'd41]: tip_q   <= {tip_q[23:0], rd_data_s1};
				default: ;
			endcase
		end
	end

	// Classification
	logic len_eth, len_ip, len_arp, ip_learn, arp_ok, proxied;

	always_comb begin
		len_eth  = len_q >= CW'(pxarp_pkg::ETH_HDR);
		len_ip   = len_q >= CW'(pxarp_pkg::ETH_HDR + pxarp_pkg::IP_MIN);
		len_arp  = len_q >= CW'(pxarp_pkg::ETH_HDR + pxarp_pkg::ARP_LEN);
		ip_learn = len_eth && len_ip && etype_q == pxarp_pkg::TYPE_IP &&
		           ipver_q == pxarp_pkg::IP_VER4;
		arp_ok   = len_eth && len_arp && etype_q == pxarp_pkg::TYPE_ARP &&
		           htype_q == pxarp_pkg::HTYPE_ETH && ptype_q == pxarp_pkg::TYPE_IP &&
		           hlen_q == pxarp_pkg::HLEN_ETH && plen_q == pxarp_pkg::PLEN_IP;
		// A nonzero ARP sender teaches the guest address before the target check
		guest_new = guest_ip_q;
		learn     = 1'b0;
		if (ip_learn) begin
			guest_new = ipsrc_q;
			learn     = 1'b1;
		end else if (arp_ok && sip_q != 32'h0) begin
			guest_new = sip_q;
			learn     = 1'b1;
		end
		proxied  = (tip_q & mask_q) == (gw_ip_q & mask_q) ||
		           tip_q == gw_ip_q || tip_q == dns_ip_q;
		do_reply = arp_ok && op_q == pxarp_pkg::OP_REQ && tip_q != sip_q &&
		           tip_q != guest_new && !leased_q && proxied;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) guest_ip_q <= '0;
		else if (state_q == pxarp_pkg::ST_DECIDE && learn) guest_ip_q <= guest_new;
	end

	// Output register: advance the reply while the sink takes bytes
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (tx_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tx_load) begin
			m_tdata_q <= pxarp_pkg::reply_byte(tx_idx_q, sha_q, gw_mac_q, tip_q, sip_q);
			m_tlast_q <= tx_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

>>> hw/rtl/pxarp_checker.sv
`default_nettype none

module pxarp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// A stalled reply byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("reply byte changed while stalled");

	// No frame byte is taken while a reply is still streaming
	a_no_rx_in_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input accepted during reply");

	// The final frame byte starts the classification pass
	a_scan_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input not stalled after final byte");

	// Nothing follows the last reply byte at once
	a_gap_after_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("reply byte after reply end");

endmodule

bind proxy_arp_responder_top pxarp_checker u_pxarp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;

	// Sizes and run limits
	localparam int HDR_BYTES     = 42;
	localparam int FRAME_MAX     = 128;
	localparam int SETTLE_CYCLES = 60;    // waits out the scan, flush and decision
	localparam int HOLD_CYCLES   = 400;   // long receiver hold-off under pressure
	localparam int STALL_LIMIT   = 3000;  // cycles without any transaction
	localparam int DRAIN_CYCLES  = 120;   // first reply byte comes after the scan, flush and decision
	localparam int PHASE_BYTES   = 30;
	localparam int PRINT_LIMIT   = 40;
	localparam int PLAN_ROWS     = 5;

	// Directed settings and addresses
	localparam logic [47:0] DIR_MAC  = 48'h0200_5E00_00FE;
	localparam logic [31:0] DIR_GW   = 32'h0A00_0001;  // 10.0.0.1
	localparam logic [31:0] DIR_MASK = 32'hFFFF_FF00;
	localparam logic [31:0] DIR_DNS  = 32'h0808_0808;  // outside the subnet
	localparam logic [47:0] SHA_G    = 48'h5254_0012_3456;
	localparam logic [47:0] SHA_ONES = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] SHA_ZERO = 48'h0;
	localparam logic [31:0] IP_55    = 32'h0A00_0037;
	localparam logic [31:0] IP_ONES  = 32'hFFFF_FFFF;
	localparam logic [31:0] IP_NONE  = 32'h0;
	localparam logic [15:0] TYPE_V6  = 16'h86DD;
	localparam logic [3:0]  IP_VER6  = 4'd6;

	typedef enum logic [2:0] {FK_SETUP, FK_ARP, FK_IP4, FK_IP6, FK_OTHER} frame_kind_e;
	typedef enum logic [2:0] {FLT_NONE, FLT_HTYPE, FLT_PTYPE, FLT_HLEN, FLT_PLEN} arp_fault_e;

	// code: ARP opcode, or ether type for FK_OTHER; sip: ARP sender, or IP source for FK_IP4/FK_IP6
	typedef struct packed {
		frame_kind_e kind;
		logic [7:0]  len;
		arp_fault_e  fault;
		logic [15:0] code;
		logic [47:0] sha;
		logic [31:0] sip;
		logic [31:0] tip;
		logic        leased;
		logic        quiet;   // 1: no reply may come
	} plan_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [63:0] pwdata   = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	// Register copies and learned state of the predictor
	logic [47:0] cfg_gw_mac = '0;
	logic [31:0] cfg_gw_ip  = '0;
	logic [31:0] cfg_mask   = '0;
	logic [31:0] cfg_dns    = '0;
	logic [7:0]  rx_store [HDR_BYTES];
	int          rx_count   = 0;
	logic [31:0] guest_ip   = '0;
	logic        quiet_frame = 1'b0;

	reply_beat_t reply_due [$];
	reply_beat_t due_beat;

	logic [7:0]  frame_buf [FRAME_MAX];
	int          frame_len;
	logic        frame_leased;

	int          idle_pct    = 0;
	int          stall_pct   = 0;
	int          hold_asked  = 0;
	int          hold_served = 0;
	int          hold_left   = 0;
	int          idle_cycles = 0;
	int          mismatches  = 0;

	// Directed frames, walked in order; quiet rows carry their expectation in the table
	plan_row_t plan [PLAN_ROWS] = '{
		// request at reset settings with extreme fields: a zero mask proxies every address
		'{FK_ARP,   42,  FLT_NONE, pxarp_pkg::OP_REQ, SHA_ONES, IP_ONES, DIR_GW,  1'b0, 1'b0},
		'{FK_SETUP, 0,   FLT_NONE, 16'h0,             SHA_ZERO, IP_NONE, IP_NONE, 1'b0, 1'b1},
		// a lone byte is too short to classify
		'{FK_OTHER, 1,   FLT_NONE, TYPE_V6,           SHA_G,    IP_NONE, IP_NONE, 1'b0, 1'b1},
		// IPv4 teaches the guest; a probe for the learned address stays silent
		'{FK_IP4,   34,  FLT_NONE, 16'h0,             SHA_G,    IP_55,   IP_NONE, 1'b0, 1'b1},
		'{FK_ARP,   42,  FLT_NONE, pxarp_pkg::OP_REQ, SHA_ZERO, IP_NONE, IP_55,   1'b0, 1'b1}
	};

	proxy_arp_responder_top #(.HEADER_BYTES(HDR_BYTES)) dut (.*);

	// Clock: period 10
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------- predictor

	function automatic logic [15:0] hdr16(input int at);
		return {rx_store[at], rx_store[at + 1]};
	endfunction

	function automatic logic [31:0] hdr32(input int at);
		return {hdr16(at), hdr16(at + 2)};
	endfunction

	// Classify the stored header at the final byte; learn the guest and queue any reply
	function automatic void classify_frame(input logic leased);
		logic [15:0]  etype;
		logic [47:0]  sha;
		logic [31:0]  sip;
		logic [31:0]  tip;
		logic [335:0] reply;
		reply_beat_t  beat;
		int           k;
		if (rx_count < pxarp_pkg::ETH_HDR)
			return;
		etype = hdr16(12);
		if (etype == pxarp_pkg::TYPE_IP) begin
			if (rx_count >= pxarp_pkg::ETH_HDR + pxarp_pkg::IP_MIN &&
					rx_store[pxarp_pkg::ETH_HDR][7:4] == pxarp_pkg::IP_VER4)
				guest_ip = hdr32(pxarp_pkg::ETH_HDR + 12);
			return;
		end
		if (etype != pxarp_pkg::TYPE_ARP || rx_count < pxarp_pkg::SCAN_LEN)
			return;
		if (hdr16(pxarp_pkg::ETH_HDR) != pxarp_pkg::HTYPE_ETH ||
				hdr16(pxarp_pkg::ETH_HDR + 2) != pxarp_pkg::TYPE_IP)
			return;
		if (rx_store[pxarp_pkg::ETH_HDR + 4] != pxarp_pkg::HLEN_ETH ||
				rx_store[pxarp_pkg::ETH_HDR + 5] != pxarp_pkg::PLEN_IP)
			return;
		sha = {hdr16(pxarp_pkg::ETH_HDR + 8), hdr32(pxarp_pkg::ETH_HDR + 10)};
		sip = hdr32(pxarp_pkg::ETH_HDR + 14);
		tip = hdr32(pxarp_pkg::ETH_HDR + 24);
		if (sip != '0)
			guest_ip = sip;
		if (hdr16(pxarp_pkg::ETH_HDR + 6) != pxarp_pkg::OP_REQ)
			return;
		if (tip == sip || tip == guest_ip || leased)
			return;
		if ((tip & cfg_mask) != (cfg_gw_ip & cfg_mask) && tip != cfg_gw_ip && tip != cfg_dns)
			return;
		reply = {sha, cfg_gw_mac, pxarp_pkg::TYPE_ARP, pxarp_pkg::HTYPE_ETH,
			pxarp_pkg::TYPE_IP, pxarp_pkg::HLEN_ETH, pxarp_pkg::PLEN_IP,
			pxarp_pkg::OP_REPLY, cfg_gw_mac, tip, sha, sip};
		if (quiet_frame)
			return;
		for (k = 0; k < pxarp_pkg::REPLY_LEN; k++) begin
			beat.data = reply[335 - 8 * k -: 8];
			beat.last = (k == pxarp_pkg::REPLY_LEN - 1);
			reply_due.push_back(beat);
		end
	endfunction

	// Store one accepted byte; the count saturates at the header size
	function automatic void take_byte(input logic [7:0] b, input logic last, input logic leased);
		if (rx_count < HDR_BYTES) begin
			rx_store[rx_count] = b;
			rx_count++;
		end
		if (last) begin
			classify_frame(leased);
			rx_count = 0;
		end
	endfunction

	// ---------------------------------------------------------------- frames

	function automatic void put_field(input int at, input logic [47:0] value, input int nbytes);
		int i;
		for (i = 0; i < nbytes; i++)
			frame_buf[at + i] = value[8 * (nbytes - 1 - i) +: 8];
	endfunction

	function automatic void fill_noise();
		int i;
		for (i = 0; i < FRAME_MAX; i++)
			frame_buf[i] = 8'($urandom);
	endfunction

	function automatic void build_arp(input logic [15:0] op, input logic [47:0] sha,
			input logic [31:0] sip, input logic [31:0] tip, input arp_fault_e fault);
		fill_noise();
		put_field(12, pxarp_pkg::TYPE_ARP, 2);
		put_field(pxarp_pkg::ETH_HDR, pxarp_pkg::HTYPE_ETH, 2);
		put_field(pxarp_pkg::ETH_HDR + 2, pxarp_pkg::TYPE_IP, 2);
		frame_buf[pxarp_pkg::ETH_HDR + 4] = pxarp_pkg::HLEN_ETH;
		frame_buf[pxarp_pkg::ETH_HDR + 5] = pxarp_pkg::PLEN_IP;
		put_field(pxarp_pkg::ETH_HDR + 6, op, 2);
		put_field(pxarp_pkg::ETH_HDR + 8, sha, 6);
		put_field(pxarp_pkg::ETH_HDR + 14, sip, 4);
		put_field(pxarp_pkg::ETH_HDR + 24, tip, 4);
		// flip one bit of the chosen header field
		case (fault)
			FLT_HTYPE: put_field(pxarp_pkg::ETH_HDR,
				pxarp_pkg::HTYPE_ETH ^ 16'(1 << $urandom_range(15)), 2);
			FLT_PTYPE: put_field(pxarp_pkg::ETH_HDR + 2,
				pxarp_pkg::TYPE_IP ^ 16'(1 << $urandom_range(15)), 2);
			FLT_HLEN:  frame_buf[pxarp_pkg::ETH_HDR + 4] =
				pxarp_pkg::HLEN_ETH ^ 8'(1 << $urandom_range(7));
			FLT_PLEN:  frame_buf[pxarp_pkg::ETH_HDR + 5] =
				pxarp_pkg::PLEN_IP ^ 8'(1 << $urandom_range(7));
			default:   ;
		endcase
	endfunction

	function automatic void build_ip(input logic [3:0] ver, input logic [31:0] src);
		fill_noise();
		put_field(12, pxarp_pkg::TYPE_IP, 2);
		frame_buf[pxarp_pkg::ETH_HDR][7:4] = ver;
		put_field(pxarp_pkg::ETH_HDR + 12, src, 4);
	endfunction

	function automatic void build_other(input logic [15:0] etype);
		fill_noise();
		put_field(12, etype, 2);
	endfunction

	function automatic logic [47:0] random_mac();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [31:0] prefix_mask(input int bits);
		return (bits == 0) ? 32'h0 : ~32'h0 << (32 - bits);
	endfunction

	function automatic logic [31:0] in_subnet();
		return (cfg_gw_ip & cfg_mask) | (32'($urandom) & ~cfg_mask);
	endfunction

	function automatic logic [31:0] pick_sender();
		int r;
		r = $urandom_range(9);
		if (r < 2)
			return '0;
		if (r < 6)
			return in_subnet();
		return 32'($urandom);
	endfunction

	// Bias targets towards the addresses the decision compares against
	function automatic logic [31:0] pick_target(input logic [31:0] sip);
		case ($urandom_range(9))
			0, 1:    return cfg_gw_ip;
			2:       return cfg_dns;
			3, 4, 5: return in_subnet();
			6:       return sip;
			7:       return guest_ip;
			default: return 32'($urandom);
		endcase
	endfunction

	// Mostly exact ARP size, some padded, a few past any byte counter wrap, a few short
	function automatic int arp_length();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 42;
		if (r < 85)
			return $urandom_range(64, 43);
		if (r < 92)
			return $urandom_range(120, 65);
		return $urandom_range(41, 28);
	endfunction

	// ---------------------------------------------------------------- drivers

	// Offer the frame byte by byte; idle before each byte at the phase's rate
	task automatic send_frame();
		int i;
		for (i = 0; i < frame_len; i++) begin
			@(negedge clk);
			while ($urandom_range(99) < idle_pct) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
			s_tvalid = 1'b1;
			s_tdata  = frame_buf[i];
			s_tlast  = (i == frame_len - 1);
			s_tuser  = s_tlast ? frame_leased : 1'($urandom);
			do @(posedge clk); while (!s_tready);
			take_byte(s_tdata, s_tlast, s_tuser);
		end
	endtask

	// Drop valid, wait out every pending reply byte, then let the block go idle
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		while (reply_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {idx, 3'b000};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		case (idx)
			pxarp_pkg::REG_GW_MAC: cfg_gw_mac = value[47:0];
			pxarp_pkg::REG_GW_IP:  cfg_gw_ip  = value[31:0];
			pxarp_pkg::REG_MASK:   cfg_mask   = value[31:0];
			pxarp_pkg::REG_DNS_IP: cfg_dns    = value[31:0];
			default:    ;
		endcase
	endtask

	// Upper data bits carry junk: only the register's own width counts
	task automatic load_config(input logic [47:0] mac, input logic [31:0] gw,
			input logic [31:0] mask, input logic [31:0] dns);
		settle();
		write_reg(pxarp_pkg::REG_GW_MAC, {16'($urandom), mac});
		write_reg(pxarp_pkg::REG_GW_IP, {32'($urandom), gw});
		write_reg(pxarp_pkg::REG_MASK, {32'($urandom), mask});
		write_reg(pxarp_pkg::REG_DNS_IP, {32'($urandom), dns});
	endtask

	task automatic random_frame();
		int          pick;
		logic [31:0] sip;
		pick = $urandom_range(99);
		sip = pick_sender();
		frame_leased = ($urandom_range(99) < 15);
		if (pick < 70) begin
			// well-formed ARP with random content, mostly requests
			build_arp(($urandom_range(99) < 90) ? pxarp_pkg::OP_REQ : 16'($urandom),
				random_mac(), sip, pick_target(sip), FLT_NONE);
			frame_len = arp_length();
		end else if (pick < 80) begin
			build_arp(pxarp_pkg::OP_REQ, random_mac(), sip, pick_target(sip),
				arp_fault_e'($urandom_range(4, 1)));
			frame_len = arp_length();
		end else if (pick < 90) begin
			build_ip(($urandom_range(99) < 70) ? pxarp_pkg::IP_VER4 : 4'($urandom), sip);
			frame_len = $urandom_range(60, 28);
		end else begin
			build_other(($urandom_range(1) == 1) ? pxarp_pkg::TYPE_ARP : 16'($urandom));
			frame_len = $urandom_range(60, 1);
		end
		send_frame();
	endtask

	task automatic run_phase(input int idle, input int stall);
		int sent;
		idle_pct  = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < PHASE_BYTES) begin
			random_frame();
			sent += frame_len;
		end
	endtask

	// ---------------------------------------------------------------- receiver

	// Stall at the phase's rate; a requested hold-off overrides it for a long stretch
	always @(negedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare every reply transaction with the oldest pending byte
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready) begin
			if (reply_due.size() == 0) begin
				report_mismatch("reply byte with nothing pending", m_tdata, 8'h00);
			end else begin
				due_beat = reply_due.pop_front();
				if (m_tdata !== due_beat.data)
					report_mismatch("reply_byte", m_tdata, due_beat.data);
				if (m_tlast !== due_beat.last)
					report_mismatch("reply_end", 8'(m_tlast), 8'(due_beat.last));
			end
		end
	end

	// Watchdog: end the run when no transaction happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int        r;
		plan_row_t row;

		// Hold reset, release on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames, no idling
		for (r = 0; r < PLAN_ROWS; r++) begin
			row = plan[r];
			if (row.kind == FK_SETUP) begin
				load_config(DIR_MAC, DIR_GW, DIR_MASK, DIR_DNS);
			end else begin
				case (row.kind)
					FK_ARP:  build_arp(row.code, row.sha, row.sip, row.tip, row.fault);
					FK_IP4:  build_ip(pxarp_pkg::IP_VER4, row.sip);
					FK_IP6:  build_ip(IP_VER6, row.sip);
					default: build_other(row.code);
				endcase
				frame_len    = row.len;
				frame_leased = row.leased;
				quiet_frame  = row.quiet;
				send_frame();
				quiet_frame  = 1'b0;
			end
		end

		// Random frames under several settings and idling patterns
		load_config(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
		run_phase(0, 0);
		load_config(48'h0, 32'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_phase(73, 0);
		load_config(random_mac(), 32'($urandom), prefix_mask($urandom_range(32)), 32'($urandom));
		run_phase(0, 73);
		load_config(random_mac(), 32'($urandom), prefix_mask($urandom_range(30, 16)),
			32'($urandom));
		run_phase(29, 29);

		// Pressure: hold the receiver off while frames keep coming, so input stalls
		load_config(random_mac(), DIR_GW, DIR_MASK, DIR_DNS);
		idle_pct  = 0;
		stall_pct = 0;
		hold_asked++;
		build_arp(pxarp_pkg::OP_REQ, random_mac(), 32'($urandom), cfg_gw_ip, FLT_NONE);
		frame_len    = 42;
		frame_leased = 1'b0;
		send_frame();
		// this frame waits behind the stalled reply
		build_other(TYPE_V6);
		frame_len    = 20;
		frame_leased = 1'b0;
		send_frame();

		// Pause the sender until every reply byte has come, then let the block drain
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && reply_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

>>> proxy_arp_responder_top.f
hw/rtl/pxarp_pkg.sv
hw/rtl/proxy_arp_responder_top.sv
hw/rtl/pxarp_checker.sv
test/testbench.sv
